// ===== rtl/core/health_state_residency_tracker_top_macros.svh =====
// ----------------------------------------------------------------------------
// Health state residency tracker assertion macros
// Shared assertion shorthands for the tracker's checkers.
// ----------------------------------------------------------------------------
`ifndef HEALTH_STATE_RESIDENCY_TRACKER_TOP_MACROS_SVH
`define HEALTH_STATE_RESIDENCY_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HSRT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tracker assertion failed");

// Next-cycle implication, disabled during reset.
`define HSRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tracker assertion failed");

`endif

// ===== rtl/core/hsrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Health state residency tracker package
// Types, status codes and the health classification shared by the tracker.
// ----------------------------------------------------------------------------
package hsrt_pkg;

  localparam int STAMP_BITS = 32;
  localparam int COUNT_BITS = 32;

  typedef enum logic [1:0] {
    ST_HEALTHY  = 2'd0,
    ST_DEGRADED = 2'd1,
    ST_FAULT    = 2'd2
  } health_t;

  localparam logic [1:0] SYS_RUNNING      = 2'd0;
  localparam logic [1:0] SYS_SENSOR_ERROR = 2'd1;

  typedef struct packed {
    health_t                 state;
    logic [STAMP_BITS-1:0]   stamp;
  } item_t;

  typedef struct packed {
    health_t                 state;
    logic                    changed;
    logic [COUNT_BITS-1:0]   degraded_entries;
    logic [COUNT_BITS-1:0]   fault_entries;
    logic [COUNT_BITS-1:0]   recovery_entries;
    logic [COUNT_BITS-1:0]   healthy_total;
    logic [COUNT_BITS-1:0]   degraded_total;
    logic [COUNT_BITS-1:0]   fault_total;
  } result_t;

  function automatic health_t classify(input logic [1:0] sys, input logic link,
                                       input logic ok);
    health_t st;
    if (sys == SYS_SENSOR_ERROR || !ok) begin
      st = ST_FAULT;
    end else if (sys == SYS_RUNNING && link) begin
      st = ST_HEALTHY;
    end else begin
      st = ST_DEGRADED;
    end
    return st;
  endfunction

endpackage

// ===== rtl/core/hsrt_in_stage.sv =====
// ----------------------------------------------------------------------------
// Tracker input stage
// Registers each input beat together with its health classification.
// ----------------------------------------------------------------------------
module hsrt_in_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    system_status,
  input  logic                          link_connected,
  input  logic                          sensor_ok,
  input  logic [hsrt_pkg::STAMP_BITS-1:0] now_ms,
  output logic                          item_valid,
  input  logic                          item_ready,
  output hsrt_pkg::item_t               item
);

  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.state <= hsrt_pkg::classify(system_status, link_connected, sensor_ok);
      item.stamp <= now_ms;
    end
  end

endmodule

// ===== rtl/core/hsrt_update.sv =====
// ----------------------------------------------------------------------------
// Tracker update stage
// Holds the latched state, counters and residency totals and registers
// one result beat per item.
// ----------------------------------------------------------------------------
module hsrt_update #(
  parameter int TIME_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  hsrt_pkg::item_t   item,
  output logic              out_valid,
  input  logic              out_ready,
  output hsrt_pkg::result_t result
);

  localparam int TW = (TIME_WIDTH > hsrt_pkg::STAMP_BITS) ? hsrt_pkg::STAMP_BITS : TIME_WIDTH;
  localparam int CW = hsrt_pkg::COUNT_BITS;

  logic                started;
  hsrt_pkg::health_t   latched;
  logic [TW-1:0]       last_stamp;
  logic [CW-1:0]       degraded_count, fault_count, recovery_count;
  logic [CW-1:0]       healthy_time, degraded_time, fault_time;

  logic                fire;
  logic [TW-1:0]       elapsed;
  logic [CW-1:0]       add;
  logic                changed;
  logic [CW-1:0]       degraded_count_next, fault_count_next, recovery_count_next;
  logic [CW-1:0]       healthy_time_next, degraded_time_next, fault_time_next;

  assign item_ready = !out_valid || out_ready;
  assign fire       = item_valid && item_ready;
  assign elapsed    = item.stamp[TW-1:0] - last_stamp;
  assign add        = CW'(elapsed);
  assign changed    = started && (item.state != latched);

  always_comb begin
    degraded_count_next = degraded_count;
    fault_count_next    = fault_count;
    recovery_count_next = recovery_count;
    healthy_time_next   = healthy_time;
    degraded_time_next  = degraded_time;
    fault_time_next     = fault_time;
    if (started) begin
      case (latched)
        hsrt_pkg::ST_HEALTHY:  healthy_time_next  = healthy_time + add;
        hsrt_pkg::ST_DEGRADED: degraded_time_next = degraded_time + add;
        hsrt_pkg::ST_FAULT:    fault_time_next    = fault_time + add;
        default: ;
      endcase
    end
    if (changed) begin
      case (item.state)
        hsrt_pkg::ST_DEGRADED: degraded_count_next = degraded_count + 1'b1;
        hsrt_pkg::ST_FAULT:    fault_count_next    = fault_count + 1'b1;
        default:               recovery_count_next = recovery_count + 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started        <= 1'b0;
      latched        <= hsrt_pkg::ST_HEALTHY;
      last_stamp     <= '0;
      degraded_count <= '0;
      fault_count    <= '0;
      recovery_count <= '0;
      healthy_time   <= '0;
      degraded_time  <= '0;
      fault_time     <= '0;
      out_valid      <= 1'b0;
    end else if (fire) begin
      started        <= 1'b1;
      latched        <= item.state;
      last_stamp     <= item.stamp[TW-1:0];
      degraded_count <= degraded_count_next;
      fault_count    <= fault_count_next;
      recovery_count <= recovery_count_next;
      healthy_time   <= healthy_time_next;
      degraded_time  <= degraded_time_next;
      fault_time     <= fault_time_next;
      out_valid      <= 1'b1;
    end else if (out_ready) begin
      out_valid      <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.state            <= item.state;
      result.changed          <= changed;
      result.degraded_entries <= degraded_count_next;
      result.fault_entries    <= fault_count_next;
      result.recovery_entries <= recovery_count_next;
      result.healthy_total    <= healthy_time_next;
      result.degraded_total   <= degraded_time_next;
      result.fault_total      <= fault_time_next;
    end
  end

endmodule

// ===== rtl/core/health_state_residency_tracker_top.sv =====
// ----------------------------------------------------------------------------
// Health state residency tracker
// Classifies each status beat as healthy, degraded or fault, counts state
// entries and accumulates the time spent in each state.
//
//   Channel  Direction  Handshake            Payload
//   in       sink       in_valid / in_ready  system_status, link_connected,
//                                            sensor_ok, now_ms
//   out      source     out_valid/out_ready  health_state, state_changed,
//                                            entry counters, residency totals
//
// An item passes from input beat to result beat through the input register,
// then through the update logic into the result register. One item is
// accepted per cycle while the output is not stalled; the rate is set by
// the update of the state, counter and total registers. A stalled output
// holds its result and back-pressure reaches in_ready in the same cycle.
// Synchronous reset clears the valid flags, latched state, counters and
// totals; the first item after reset only latches its state and timestamp.
// ----------------------------------------------------------------------------
module health_state_residency_tracker_top #(
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  system_status,
  input  logic        link_connected,
  input  logic        sensor_ok,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  health_state,
  output logic        state_changed,
  output logic [31:0] degraded_entries,
  output logic [31:0] fault_entries,
  output logic [31:0] recovery_entries,
  output logic [31:0] healthy_total_ms,
  output logic [31:0] degraded_total_ms,
  output logic [31:0] fault_total_ms
);

  logic              item_valid;
  logic              item_ready;
  hsrt_pkg::item_t   item;
  hsrt_pkg::result_t result;

  hsrt_in_stage u_in_stage (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .system_status  (system_status),
    .link_connected (link_connected),
    .sensor_ok      (sensor_ok),
    .now_ms         (now_ms),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item)
  );

  hsrt_update #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_update (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  assign health_state      = result.state;
  assign state_changed     = result.changed;
  assign degraded_entries  = result.degraded_entries;
  assign fault_entries     = result.fault_entries;
  assign recovery_entries  = result.recovery_entries;
  assign healthy_total_ms  = result.healthy_total;
  assign degraded_total_ms = result.degraded_total;
  assign fault_total_ms    = result.fault_total;

endmodule

// ===== rtl/core/hsrt_checker.sv =====
// ----------------------------------------------------------------------------
// Tracker port checker
// Watches the tracker's ports for result consistency across beats.
// ----------------------------------------------------------------------------
`include "health_state_residency_tracker_top_macros.svh"

module hsrt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  system_status,
  input logic        link_connected,
  input logic        sensor_ok,
  input logic [31:0] now_ms,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  health_state,
  input logic        state_changed,
  input logic [31:0] degraded_entries,
  input logic [31:0] fault_entries,
  input logic [31:0] recovery_entries,
  input logic [31:0] healthy_total_ms,
  input logic [31:0] degraded_total_ms,
  input logic [31:0] fault_total_ms
);

  logic        seen;
  logic [31:0] prev_sum;
  logic [31:0] entry_sum;

  assign entry_sum = degraded_entries + fault_entries + recovery_entries;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen     <= 1'b0;
      prev_sum <= '0;
    end else if (out_valid && out_ready) begin
      seen     <= 1'b1;
      prev_sum <= entry_sum;
    end
  end

  // A waiting input beat stays valid with its payload unchanged.
  `HSRT_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && !in_ready,
                    in_valid && $stable(system_status) && $stable(link_connected) &&
                    $stable(sensor_ok) && $stable(now_ms))

  // A stalled result beat stays valid.
  `HSRT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // The first result after reset reports no change and no entries.
  `HSRT_ASSERT_NOW(a_first_result, clk, rst, out_valid && !seen,
                   !state_changed && entry_sum == 32'd0)

  // Each change adds exactly one entry over the previous result.
  `HSRT_ASSERT_NOW(a_change_counts, clk, rst, out_valid && seen && state_changed,
                   entry_sum == prev_sum + 32'd1)

  // Without a change no entry counter moves.
  `HSRT_ASSERT_NOW(a_no_change_counts, clk, rst, out_valid && seen && !state_changed,
                   entry_sum == prev_sum)

endmodule

bind health_state_residency_tracker_top hsrt_checker u_hsrt_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Health state residency tracker testbench
// Drives status beats with random gaps into the tracker, predicts each result
// beat from a local model of the classification, entry counters and residency
// totals, and compares every result field by field in arrival order. The
// output side stalls at random and once holds off long enough to back up the
// input.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_ITEMS = 900;
  localparam int REPORT_LIMIT = 10;
  localparam int HOLD_AT_BEAT = 400;
  localparam int HOLD_CYCLES = 300;

  class residency_scoreboard;
    bit started;
    hsrt_pkg::health_t latched;
    logic [31:0] last_stamp;
    logic [31:0] degraded_count;
    logic [31:0] fault_count;
    logic [31:0] recovery_count;
    logic [31:0] healthy_ms;
    logic [31:0] degraded_ms;
    logic [31:0] fault_ms;
    hsrt_pkg::result_t expected_q[$];
    int mismatches;

    function new();
      started = 1'b0;
      latched = hsrt_pkg::ST_HEALTHY;
      last_stamp = '0;
      degraded_count = '0;
      fault_count = '0;
      recovery_count = '0;
      healthy_ms = '0;
      degraded_ms = '0;
      fault_ms = '0;
      mismatches = 0;
    endfunction

    function hsrt_pkg::health_t grade_status(logic [1:0] sys, logic link, logic ok);
      if (sys == hsrt_pkg::SYS_SENSOR_ERROR || ok == 1'b0) begin
        return hsrt_pkg::ST_FAULT;
      end
      if (sys == hsrt_pkg::SYS_RUNNING && link == 1'b1) begin
        return hsrt_pkg::ST_HEALTHY;
      end
      return hsrt_pkg::ST_DEGRADED;
    endfunction

    function void note_status(logic [1:0] sys, logic link, logic ok, logic [31:0] stamp);
      hsrt_pkg::health_t graded;
      logic [31:0] elapsed;
      hsrt_pkg::result_t r;
      graded = grade_status(sys, link, ok);
      r.changed = 1'b0;
      if (!started) begin
        started = 1'b1;
        latched = graded;
      end else begin
        elapsed = stamp - last_stamp;
        case (latched)
          hsrt_pkg::ST_HEALTHY: healthy_ms = healthy_ms + elapsed;
          hsrt_pkg::ST_DEGRADED: degraded_ms = degraded_ms + elapsed;
          hsrt_pkg::ST_FAULT: fault_ms = fault_ms + elapsed;
          default: ;
        endcase
        if (graded != latched) begin
          r.changed = 1'b1;
          case (graded)
            hsrt_pkg::ST_DEGRADED: degraded_count = degraded_count + 1;
            hsrt_pkg::ST_FAULT: fault_count = fault_count + 1;
            default: recovery_count = recovery_count + 1;
          endcase
          latched = graded;
        end
      end
      last_stamp = stamp;
      r.state = graded;
      r.degraded_entries = degraded_count;
      r.fault_entries = fault_count;
      r.recovery_entries = recovery_count;
      r.healthy_total = healthy_ms;
      r.degraded_total = degraded_ms;
      r.fault_total = fault_ms;
      expected_q.push_back(r);
    endfunction

    function void check_field(string label, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, label, want, got);
        end
      end
    endfunction

    function void check_result(logic [1:0] st, logic chg, logic [31:0] de, logic [31:0] fe,
                               logic [31:0] re, logic [31:0] ht, logic [31:0] dt,
                               logic [31:0] ft);
      hsrt_pkg::result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: result beat arrived with nothing outstanding", $realtime);
        end
        return;
      end
      want = expected_q.pop_front();
      check_field("health_state", 32'(want.state), 32'(st));
      check_field("state_changed", 32'(want.changed), 32'(chg));
      check_field("degraded_entries", want.degraded_entries, de);
      check_field("fault_entries", want.fault_entries, fe);
      check_field("recovery_entries", want.recovery_entries, re);
      check_field("healthy_total_ms", want.healthy_total, ht);
      check_field("degraded_total_ms", want.degraded_total, dt);
      check_field("fault_total_ms", want.fault_total, ft);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [1:0] system_status;
  logic link_connected;
  logic sensor_ok;
  logic [31:0] now_ms;
  logic out_valid;
  logic out_ready;
  logic [1:0] health_state;
  logic state_changed;
  logic [31:0] degraded_entries;
  logic [31:0] fault_entries;
  logic [31:0] recovery_entries;
  logic [31:0] healthy_total_ms;
  logic [31:0] degraded_total_ms;
  logic [31:0] fault_total_ms;

  residency_scoreboard tracker_sb = new();
  int sent_beats = 0;
  int seen_beats = 0;

  health_state_residency_tracker_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .system_status(system_status),
    .link_connected(link_connected),
    .sensor_ok(sensor_ok),
    .now_ms(now_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .health_state(health_state),
    .state_changed(state_changed),
    .degraded_entries(degraded_entries),
    .fault_entries(fault_entries),
    .recovery_entries(recovery_entries),
    .healthy_total_ms(healthy_total_ms),
    .degraded_total_ms(degraded_total_ms),
    .fault_total_ms(fault_total_ms)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Every fourth stretch of 48 beats runs without idling on that side.
  function automatic int idle_draw(int beat_index, int phase);
    if (((beat_index + phase) / 48) % 4 == 0) begin
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  task automatic send_status(logic [1:0] sys, logic link, logic ok, logic [31:0] stamp);
    int gap;
    gap = idle_draw(sent_beats, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    system_status <= sys;
    link_connected <= link;
    sensor_ok <= ok;
    now_ms <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker_sb.note_status(sys, link, ok, stamp);
    sent_beats++;
  endtask

  task automatic collect_results();
    int wait_cycles;
    forever begin
      wait_cycles = (seen_beats == HOLD_AT_BEAT) ? HOLD_CYCLES : idle_draw(seen_beats, 24);
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      tracker_sb.check_result(health_state, state_changed, degraded_entries, fault_entries,
                              recovery_entries, healthy_total_ms, degraded_total_ms,
                              fault_total_ms);
      seen_beats++;
    end
  endtask

  task automatic run_directed();
    logic [31:0] stamp;
    // The first beat only latches; the second crosses the timestamp wrap.
    send_status(hsrt_pkg::SYS_RUNNING, 1'b1, 1'b1, 32'hFFFF_FFF0);
    send_status(hsrt_pkg::SYS_RUNNING, 1'b1, 1'b1, 32'h0000_0010);
    send_status(hsrt_pkg::SYS_RUNNING, 1'b0, 1'b1, 32'h0000_0020);
    send_status(hsrt_pkg::SYS_SENSOR_ERROR, 1'b1, 1'b1, 32'h0000_0100);
    send_status(hsrt_pkg::SYS_RUNNING, 1'b1, 1'b1, 32'h0000_0100);
    send_status(hsrt_pkg::SYS_RUNNING, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_status(hsrt_pkg::SYS_RUNNING, 1'b1, 1'b1, 32'h0000_0000);
    send_status(hsrt_pkg::SYS_RUNNING, 1'b1, 1'b0, 32'hFFFF_FFFF);
    send_status(2'd3, 1'b1, 1'b1, 32'h7FFF_FFFF);
    send_status(2'd3, 1'b1, 1'b1, 32'h8000_0000);
    stamp = 32'h8000_0000;
    for (int k = 0; k < 16; k++) begin
      stamp = stamp + 32'h0123_4567;
      send_status(k[3:2], k[1], k[0], stamp);
    end
  endtask

  task automatic run_random();
    logic [31:0] stamp;
    logic [1:0] sys;
    logic link;
    logic ok;
    int pick;
    stamp = $urandom();
    sys = hsrt_pkg::SYS_RUNNING;
    link = 1'b1;
    ok = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        sys = 2'($urandom_range(0, 3));
        link = 1'($urandom_range(0, 1));
        ok = ($urandom_range(0, 5) != 0);
      end
      pick = $urandom_range(0, 15);
      case (pick)
        0: stamp = $urandom();
        1: stamp = stamp + $urandom();
        2: stamp = stamp;
        default: stamp = stamp + $urandom_range(1, 5000);
      endcase
      send_status(sys, link, ok, stamp);
    end
  endtask

  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    out_ready <= 1'b0;
    system_status <= '0;
    link_connected <= 1'b0;
    sensor_ok <= 1'b0;
    now_ms <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    fork
      collect_results();
    join_none
    run_directed();
    run_random();
    in_valid <= 1'b0;
    while (tracker_sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker_sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
